[sv/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define FBPA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define FBPA_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

[sv/fbpa_pkg.sv]
// Package for the fixed block pool allocator: widths, codes and shared types.
// No dependencies; fbpa_if, fbpa_engine, the core and the testbench refer to it by scoped names.
package fbpa_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int LINK_W     = IDX_W + 1;
  localparam int CNT_W      = 9;
  localparam int SIZE_W     = 13;
  localparam int OFF_W      = 20;
  localparam int PROD_W     = IDX_W + SIZE_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(4096);

  localparam logic [CNT_W-1:0]  RESET_COUNT = CNT_W'(256);
  localparam logic [SIZE_W-1:0] RESET_SIZE  = SIZE_W'(64);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CNT_W-1:0]  block_count;
    logic [SIZE_W-1:0] block_size;
  } cfg_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] granted_index;
    logic [OFF_W-1:0] byte_offset;
  } res_t;

endpackage

[sv/fbpa_if.sv]
// Channel interfaces of the allocator: request, result and configuration write.
// Depends on fbpa_pkg for the field widths.
interface fbpa_req_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [fbpa_pkg::IDX_W-1:0] block_index;
  modport source (output valid, output op, output block_index, input ready);
  modport sink   (input valid, input op, input block_index, output ready);
endinterface

interface fbpa_res_if;
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic [fbpa_pkg::IDX_W-1:0] granted_index;
  logic [fbpa_pkg::OFF_W-1:0] byte_offset;
  modport source (output valid, output ok, output granted_index, output byte_offset,
                  input ready);
  modport sink   (input valid, input ok, input granted_index, input byte_offset,
                  output ready);
endinterface

interface fbpa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fbpa_pkg::CFG_IDX_W-1:0]  index;
  logic [fbpa_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/fixed_block_pool_allocator_core.sv]
// Top level of the fixed block pool allocator: configuration registers and
// the result output register. Depends on fbpa_pkg, fbpa_if and fbpa_engine.
//
// Channels: req carries one request (op 0 allocate, 1 free, with block_index
// for a free); res returns exactly one result per request in request order;
// cfg writes block_count (index 0) or block_size (index 1) and is ready
// whenever reset is low. Configuration is to be written only while no request
// is in flight. A result passes from the engine into the output register as
// soon as that register can take it. One request is worked on at a time,
// so a new request is taken only after the engine has passed on its result;
// a pop from the free list reads the next link from the link memory, whose read
// is registered. The request after a result may be accepted while that result
// still waits in the output register; if res stays stalled, the engine holds
// its finished result and stops taking requests until the output register
// frees up. Reset empties the free list, restarts the never-used block counter
// at zero and restores block_count 256 and block_size 64; the link memory
// needs no clearing, since an entry is always written before it can be read.
module fixed_block_pool_allocator_core (
  input  logic           clk,
  input  logic           rst,
  fbpa_cfg_if.sink       cfg,
  fbpa_req_if.sink       req,
  fbpa_res_if.source     res
);

  fbpa_pkg::cfg_t cfg_regs;
  logic           eng_res_valid;
  logic           eng_res_ready;
  fbpa_pkg::res_t eng_res;
  logic           out_valid;
  fbpa_pkg::res_t out_data;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.block_count <= fbpa_pkg::RESET_COUNT;
      cfg_regs.block_size  <= fbpa_pkg::RESET_SIZE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fbpa_pkg::CFG_BLOCK_COUNT: begin
          cfg_regs.block_count <= cfg.data[fbpa_pkg::CNT_W-1:0];
        end
        fbpa_pkg::CFG_BLOCK_SIZE: begin
          cfg_regs.block_size <= cfg.data[fbpa_pkg::SIZE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  fbpa_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_op     (req.op),
    .in_index  (req.block_index),
    .res_valid (eng_res_valid),
    .res_ready (eng_res_ready),
    .res       (eng_res)
  );

  assign eng_res_ready = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_res_ready) begin
      out_valid <= eng_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_ready && eng_res_valid) begin
      out_data <= eng_res;
    end
  end

  assign res.valid         = out_valid;
  assign res.ok            = out_data.ok;
  assign res.granted_index = out_data.granted_index;
  assign res.byte_offset   = out_data.byte_offset;

endmodule

[sv/fbpa_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/fbpa_engine.sv]
// Free-list engine: list head, never-used counter, link memory and offset multiply.
// Depends on fbpa_pkg, fbpa_ram and assert_macros.svh.
`include "assert_macros.svh"

module fbpa_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  fbpa_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic [fbpa_pkg::IDX_W-1:0] in_index,
  output logic                       res_valid,
  input  logic                       res_ready,
  output fbpa_pkg::res_t             res
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_PEND} state_t;

  state_t                        state;
  logic [fbpa_pkg::LINK_W-1:0]   free_head;
  logic [fbpa_pkg::CNT_W-1:0]    fresh_count;
  logic [fbpa_pkg::IDX_W-1:0]    grant;
  logic                          from_list;
  fbpa_pkg::res_t                pend;

  logic [fbpa_pkg::CNT_W-1:0]    eff_count;
  logic [fbpa_pkg::SIZE_W-1:0]   eff_size;
  logic [fbpa_pkg::PROD_W-1:0]   prod;
  logic [fbpa_pkg::LINK_W-1:0]   link_rdata;
  logic                          accept;
  logic                          head_avail;
  logic                          idx_ok;
  logic                          link_we;
  logic                          link_re;
  fbpa_pkg::res_t                mul_res;

  always_comb begin
    if (cfg.block_count > fbpa_pkg::CNT_W'(fbpa_pkg::NUM_BLOCKS)) begin
      eff_count = fbpa_pkg::CNT_W'(fbpa_pkg::NUM_BLOCKS);
    end else begin
      eff_count = cfg.block_count;
    end
    if (cfg.block_size < fbpa_pkg::MIN_SIZE) begin
      eff_size = fbpa_pkg::MIN_SIZE;
    end else if (cfg.block_size > fbpa_pkg::MAX_SIZE) begin
      eff_size = fbpa_pkg::MAX_SIZE;
    end else begin
      eff_size = cfg.block_size;
    end
  end

  // No request is taken while reset is held.
  assign in_ready   = (state == S_IDLE) && !rst;
  assign accept     = in_valid && in_ready;
  assign head_avail = free_head < fbpa_pkg::LINK_W'(fbpa_pkg::NUM_BLOCKS);
  assign idx_ok     = fbpa_pkg::CNT_W'(in_index) < eff_count;
  assign link_we    = accept && (in_op == fbpa_pkg::OP_FREE) && idx_ok;
  assign link_re    = accept && (in_op == fbpa_pkg::OP_ALLOC) && head_avail;

  // The pushed block takes the old head as its link.
  fbpa_ram #(
    .WIDTH (fbpa_pkg::LINK_W),
    .DEPTH (fbpa_pkg::NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (in_index),
    .wdata (free_head),
    .re    (link_re),
    .raddr (free_head[fbpa_pkg::IDX_W-1:0]),
    .rdata (link_rdata)
  );

  assign prod    = fbpa_pkg::PROD_W'(grant) * fbpa_pkg::PROD_W'(eff_size);
  assign mul_res = '{ok: 1'b1, granted_index: grant,
                     byte_offset: prod[fbpa_pkg::OFF_W-1:0]};

  assign res_valid = (state == S_MUL) || (state == S_PEND);
  assign res       = (state == S_MUL) ? mul_res : pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_head   <= fbpa_pkg::LINK_W'(fbpa_pkg::NUM_BLOCKS);
      fresh_count <= '0;
      from_list   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_op == fbpa_pkg::OP_ALLOC) begin
              if (head_avail) begin
                grant     <= free_head[fbpa_pkg::IDX_W-1:0];
                from_list <= 1'b1;
                state     <= S_MUL;
              end else if (fresh_count < eff_count) begin
                grant       <= fresh_count[fbpa_pkg::IDX_W-1:0];
                fresh_count <= fresh_count + fbpa_pkg::CNT_W'(1);
                from_list   <= 1'b0;
                state       <= S_MUL;
              end else begin
                pend  <= '0;
                state <= S_PEND;
              end
            end else begin
              pend <= '{ok: idx_ok, granted_index: '0, byte_offset: '0};
              if (idx_ok) begin
                free_head <= fbpa_pkg::LINK_W'(in_index);
              end
              state <= S_PEND;
            end
          end
        end
        S_MUL: begin
          // The link read issued at acceptance is valid in this cycle.
          if (from_list) begin
            free_head <= link_rdata;
          end
          pend <= mul_res;
          if (res_ready) begin
            state <= S_IDLE;
          end else begin
            state <= S_PEND;
          end
        end
        S_PEND: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FBPA_ASSERT(a_fresh_bound, fresh_count <= fbpa_pkg::CNT_W'(fbpa_pkg::NUM_BLOCKS), "fresh count past pool size")
  `FBPA_ASSERT_NEXT(a_list_pop, link_re, (state == S_MUL) && from_list, "list pop lost its link read")
  `FBPA_ASSERT_NEXT(a_push_head, link_we, free_head == fbpa_pkg::LINK_W'($past(in_index)), "pushed block is not the new head")
  `FBPA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && (res == $past(res)), "stalled result changed")

endmodule

[test/fixed_block_pool_allocator_core_tb.sv]
// Self-checking testbench for the fixed block pool allocator core.
// Drives requests and register writes through the channel interfaces of fbpa_if
// and checks each result against a free-list predictor built on fbpa_pkg types.
`timescale 1ns / 1ps

class alloc_scoreboard;
  logic [fbpa_pkg::LINK_W-1:0] link_mem [fbpa_pkg::NUM_BLOCKS];
  logic [fbpa_pkg::LINK_W-1:0] list_head;
  logic [fbpa_pkg::CNT_W-1:0]  fresh_next;
  logic [fbpa_pkg::CNT_W-1:0]  pool_count;
  logic [fbpa_pkg::SIZE_W-1:0] pool_size;
  fbpa_pkg::res_t              pending_grants [$];
  int                          mismatches;

  function new();
    list_head  = fbpa_pkg::LINK_W'(fbpa_pkg::NUM_BLOCKS);
    fresh_next = '0;
    pool_count = fbpa_pkg::RESET_COUNT;
    pool_size  = fbpa_pkg::RESET_SIZE;
    mismatches = 0;
  endfunction

  function void write_reg(logic [fbpa_pkg::CFG_IDX_W-1:0] idx,
                          logic [fbpa_pkg::CFG_DATA_W-1:0] data);
    if (idx == fbpa_pkg::CFG_BLOCK_COUNT) begin
      pool_count = data[fbpa_pkg::CNT_W-1:0];
    end else begin
      pool_size = data[fbpa_pkg::SIZE_W-1:0];
    end
  endfunction

  // Works out the result of an accepted request and queues it.
  function fbpa_pkg::res_t note_request(logic op, logic [fbpa_pkg::IDX_W-1:0] idx);
    fbpa_pkg::res_t r;
    int limit;
    int bsize;
    limit = (pool_count > fbpa_pkg::NUM_BLOCKS) ? fbpa_pkg::NUM_BLOCKS : int'(pool_count);
    if (pool_size < fbpa_pkg::MIN_SIZE) bsize = int'(fbpa_pkg::MIN_SIZE);
    else if (pool_size > fbpa_pkg::MAX_SIZE) bsize = int'(fbpa_pkg::MAX_SIZE);
    else bsize = int'(pool_size);
    r = '0;
    if (op == fbpa_pkg::OP_ALLOC) begin
      if (list_head < fbpa_pkg::NUM_BLOCKS) begin
        r.granted_index = list_head[fbpa_pkg::IDX_W-1:0];
        list_head = link_mem[list_head[fbpa_pkg::IDX_W-1:0]];
        r.ok = 1'b1;
      end else if (fresh_next < limit) begin
        r.granted_index = fresh_next[fbpa_pkg::IDX_W-1:0];
        fresh_next = fresh_next + 1'b1;
        r.ok = 1'b1;
      end
      if (r.ok) r.byte_offset = fbpa_pkg::OFF_W'(int'(r.granted_index) * bsize);
    end else if (idx < limit) begin
      link_mem[idx] = list_head;
      list_head = fbpa_pkg::LINK_W'(idx);
      r.ok = 1'b1;
    end
    pending_grants.push_back(r);
    return r;
  endfunction

  function void check_result(fbpa_pkg::res_t got);
    fbpa_pkg::res_t want;
    if (pending_grants.size() == 0) begin
      if (mismatches < 10)
        $display("result with no request waiting: ok=%0d index=%0d offset=%0d",
                 got.ok, got.granted_index, got.byte_offset);
      mismatches++;
    end else begin
      want = pending_grants.pop_front();
      if (got.ok !== want.ok || got.granted_index !== want.granted_index ||
          got.byte_offset !== want.byte_offset) begin
        if (mismatches < 10)
          $display({"result mismatch: expected ok=%0d index=%0d offset=%0d, ",
                    "got ok=%0d index=%0d offset=%0d"},
                   want.ok, want.granted_index, want.byte_offset,
                   got.ok, got.granted_index, got.byte_offset);
        mismatches++;
      end
    end
  endfunction

  function int outstanding();
    return pending_grants.size();
  endfunction
endclass

module fixed_block_pool_allocator_core_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 120;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst;

  fbpa_cfg_if cfg_ch ();
  fbpa_req_if req_ch ();
  fbpa_res_if res_ch ();

  fixed_block_pool_allocator_core DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .res (res_ch)
  );

  alloc_scoreboard sb = new();

  int             cycle_count = 0;
  bit             idling_on = 1'b1;
  bit             hold_request = 1'b0;
  int             rx_stall_left = 0;
  int             rx_hold_left = 0;
  bit             rx_ready;
  int             cur_count = fbpa_pkg::NUM_BLOCKS;
  logic [fbpa_pkg::IDX_W-1:0] held_blocks [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        rx_ready = 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        rx_hold_left = HOLD_CYCLES - 1;
        rx_ready = 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        rx_ready = 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        rx_stall_left = $urandom_range(1, 18) - 1;
        rx_ready = 1'b0;
      end else begin
        rx_ready = 1'b1;
      end
      res_ch.ready <= rx_ready;
    end
  end

  always @(posedge clk) begin
    fbpa_pkg::res_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.ok            = res_ch.ok;
      got.granted_index = res_ch.granted_index;
      got.byte_offset   = res_ch.byte_offset;
      sb.check_result(got);
    end
  end

  // Offers one request, with an occasional idle burst before it, and waits
  // until it is taken. Valid stays high afterwards for a back-to-back request.
  task automatic send_request(logic op, logic [fbpa_pkg::IDX_W-1:0] idx);
    fbpa_pkg::res_t granted;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.block_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    granted = sb.note_request(op, idx);
    if (op == fbpa_pkg::OP_ALLOC && granted.ok) held_blocks.push_back(granted.granted_index);
  endtask

  task automatic write_register(logic [fbpa_pkg::CFG_IDX_W-1:0] idx,
                                logic [fbpa_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.write_reg(idx, data);
    if (idx == fbpa_pkg::CFG_BLOCK_COUNT) cur_count = int'(data[fbpa_pkg::CNT_W-1:0]);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int                              alloc_pct;
    int                              pick;
    int                              k;
    int                              limit;
    logic [fbpa_pkg::IDX_W-1:0]      idx;
    logic [fbpa_pkg::CFG_DATA_W-1:0] cdata;

    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.op          <= fbpa_pkg::OP_ALLOC;
    req_ch.block_index <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= fbpa_pkg::CFG_BLOCK_COUNT;
    cfg_ch.data        <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Fresh grants in order, most recent free reused first, a free of a block
    // never handed out, and a double free after which the same block is granted three times.
    repeat (3) send_request(fbpa_pkg::OP_ALLOC, fbpa_pkg::IDX_W'($urandom));
    send_request(fbpa_pkg::OP_FREE, 8'd1);
    send_request(fbpa_pkg::OP_FREE, 8'd2);
    repeat (2) send_request(fbpa_pkg::OP_ALLOC, fbpa_pkg::IDX_W'($urandom));
    send_request(fbpa_pkg::OP_FREE, 8'd255);
    send_request(fbpa_pkg::OP_ALLOC, 8'd0);
    send_request(fbpa_pkg::OP_FREE, 8'd0);
    send_request(fbpa_pkg::OP_FREE, 8'd0);
    repeat (3) send_request(fbpa_pkg::OP_ALLOC, 8'hFF);
    drain_results();

    // A count of zero: nothing fresh is granted and every free is invalid.
    write_register(fbpa_pkg::CFG_BLOCK_COUNT, '0);
    send_request(fbpa_pkg::OP_ALLOC, 8'd0);
    send_request(fbpa_pkg::OP_FREE, 8'd0);
    send_request(fbpa_pkg::OP_FREE, 8'd255);
    drain_results();

    // Count above the pool size, and block sizes below 8 and above 4096.
    write_register(fbpa_pkg::CFG_BLOCK_COUNT, 13'h1FFF);
    write_register(fbpa_pkg::CFG_BLOCK_SIZE, 13'd1);
    send_request(fbpa_pkg::OP_ALLOC, 8'd0);
    send_request(fbpa_pkg::OP_FREE, 8'd200);
    drain_results();
    write_register(fbpa_pkg::CFG_BLOCK_SIZE, 13'h1FFF);
    send_request(fbpa_pkg::OP_ALLOC, 8'd0);
    drain_results();
    write_register(fbpa_pkg::CFG_BLOCK_SIZE, 13'd4096);
    send_request(fbpa_pkg::OP_ALLOC, 8'd0);
    drain_results();

    // A count of 6 with block size 8; the grants here come from the free list.
    write_register(fbpa_pkg::CFG_BLOCK_COUNT, 13'd6);
    write_register(fbpa_pkg::CFG_BLOCK_SIZE, 13'd8);
    send_request(fbpa_pkg::OP_ALLOC, 8'd0);
    send_request(fbpa_pkg::OP_FREE, 8'd5);
    send_request(fbpa_pkg::OP_ALLOC, 8'd0);
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      idling_on = (ph < PHASES - 3);
      if (ph == 0) begin
        write_register(fbpa_pkg::CFG_BLOCK_COUNT, 13'd256);
        write_register(fbpa_pkg::CFG_BLOCK_SIZE, 13'd4096);
      end else if (ph == 1) begin
        write_register(fbpa_pkg::CFG_BLOCK_COUNT, 13'd1);
        write_register(fbpa_pkg::CFG_BLOCK_SIZE, 13'd1);
      end else begin
        case ($urandom_range(0, 6))
          0:       cdata = 13'd1;
          1:       cdata = fbpa_pkg::CFG_DATA_W'($urandom_range(2, 8));
          2:       cdata = fbpa_pkg::CFG_DATA_W'($urandom_range(9, 255));
          3:       cdata = 13'd256;
          4:       cdata = fbpa_pkg::CFG_DATA_W'($urandom_range(257, 8191));
          5:       cdata = fbpa_pkg::CFG_DATA_W'($urandom_range(0, 1));
          default: cdata = fbpa_pkg::CFG_DATA_W'($urandom_range(1, 64));
        endcase
        write_register(fbpa_pkg::CFG_BLOCK_COUNT, cdata);
        case ($urandom_range(0, 3))
          0:       cdata = fbpa_pkg::CFG_DATA_W'($urandom_range(0, 8));
          1:       cdata = 13'd4096;
          2:       cdata = fbpa_pkg::CFG_DATA_W'($urandom_range(4097, 8191));
          default: cdata = fbpa_pkg::CFG_DATA_W'($urandom_range(9, 4095));
        endcase
        write_register(fbpa_pkg::CFG_BLOCK_SIZE, cdata);
      end
      alloc_pct = $urandom_range(30, 70);
      if (ph == 2) hold_request = 1'b1;
      limit = (cur_count > fbpa_pkg::NUM_BLOCKS) ? fbpa_pkg::NUM_BLOCKS : cur_count;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          send_request(fbpa_pkg::OP_ALLOC, fbpa_pkg::IDX_W'($urandom));
        end else begin
          // Mostly return a block that is held; sometimes a block in range
          // that may already be free, sometimes any index at all.
          pick = $urandom_range(0, 99);
          if (pick < 75 && held_blocks.size() > 0) begin
            k = $urandom_range(0, held_blocks.size() - 1);
            idx = held_blocks[k];
            held_blocks.delete(k);
          end else if (pick < 90 && limit > 0) begin
            idx = fbpa_pkg::IDX_W'($urandom_range(0, limit - 1));
          end else begin
            idx = fbpa_pkg::IDX_W'($urandom_range(0, 255));
          end
          send_request(fbpa_pkg::OP_FREE, idx);
        end
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/fbpa_pkg.sv
sv/fbpa_if.sv
sv/fbpa_ram.sv
sv/fbpa_engine.sv
sv/fixed_block_pool_allocator_core.sv
test/fixed_block_pool_allocator_core_tb.sv
